// ===== rtl/core/lfsr_spreading_code_packer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// LFSR spreading code packer: assertion macros
// Shared property forms for the checker of the packer unit.
// ----------------------------------------------------------------------------
`ifndef LFSR_SPREADING_CODE_PACKER_UNIT_ASSERT_SVH
`define LFSR_SPREADING_CODE_PACKER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSCP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lscp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LSCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lscp assertion failed");

`endif

// ===== rtl/core/lscp_pkg.sv =====
// ----------------------------------------------------------------------------
// LFSR spreading code packer package
// Types, register indexes, status codes and reset constants.
// ----------------------------------------------------------------------------
package lscp_pkg;

  // Default upper limit on the bits of one request.
  localparam int unsigned MaxBitsDefault = 512;

  // Widths of the register file and fields.
  localparam int unsigned DegreeW = 6;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 10;
  localparam int unsigned CfgIdxW = 2;

  // Reset values of the configuration registers.
  localparam logic [DegreeW-1:0] DegreeReset = 6'd2;
  localparam logic [WordW-1:0]   TapReset    = 32'hC000_0000;
  localparam logic [WordW-1:0]   SeedReset   = 32'h8000_0000;

  // Legal degree range.
  localparam logic [DegreeW-1:0] DegreeMin = 6'd2;
  localparam logic [DegreeW-1:0] DegreeMax = 6'd32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEGREE = 2'd0,
    CFG_TAPS   = 2'd1,
    CFG_SEED   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_COUNT = 3'd1,
    ST_BAD_DEGREE = 3'd2,
    ST_NO_G0      = 3'd3,
    ST_STRAY_TAPS = 3'd4
  } status_e;

endpackage

// ===== rtl/core/lfsr_spreading_code_packer_unit.sv =====
// ----------------------------------------------------------------------------
// LFSR spreading code packer unit
// Fibonacci LFSR of degree 2 to 32 that packs code bits into bytes.
// ----------------------------------------------------------------------------
// A request carries a bit count; the unit answers with ceil(count/8) bytes,
// earliest code bit in the MSB, the final byte zero padded and flagged last.
// A single LFSR step unit runs one code bit per clock while a byte is being
// filled; a request of N bits (N clipped to MaxBits) is stepped bit by bit and
// each full byte is held for hand-off until the output side takes it.
// Configuration or count errors give a single flagged byte in the next cycle.
// The unit takes a new request only once the last byte has been taken.
// A write to the degree, tap or seed register reloads the LFSR from the seed.
// ----------------------------------------------------------------------------
module lfsr_spreading_code_packer_unit #(
  parameter int unsigned MaxBits = lscp_pkg::MaxBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [lscp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lscp_pkg::WordW-1:0]   cfg_wdata_i,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lscp_pkg::CountW-1:0]  bit_count_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   code_byte_o,
  output logic                         last_byte_o,
  output logic [2:0]                   status_o
);
  import lscp_pkg::*;

  localparam int unsigned RemW = $clog2(MaxBits + 1);
  localparam int unsigned CmpW = (RemW > CountW) ? RemW : CountW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [DegreeW-1:0]   degree_q;
  logic [WordW-1:0]     taps_q;
  logic [WordW-1:0]     seed_q;
  logic [WordW-1:0]     lfsr_q, lfsr_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [2:0]           bit_idx_q, bit_idx_d;
  logic [7:0]           byte_q, byte_d;
  logic                 last_q, last_d;
  status_e              status_q, status_d;

  logic [WordW-1:0]     deg_mask;
  logic [DegreeW-1:0]   out_pos;
  logic                 degree_ok;
  logic                 g0_ok;
  logic                 taps_ok;
  logic                 feedback;
  logic                 code_bit;
  logic [WordW-1:0]     lfsr_step;
  logic [CmpW-1:0]      count_ext;
  logic [RemW-1:0]      count_sat;
  logic                 req_accept;
  logic                 rsp_accept;

  // Configuration checks and the shared LFSR step unit.
  assign deg_mask  = ~({WordW{1'b1}} >> degree_q);
  assign out_pos   = DegreeMax - degree_q;
  assign degree_ok = (degree_q >= DegreeMin) && (degree_q <= DegreeMax);
  assign g0_ok     = taps_q[out_pos[4:0]];
  assign taps_ok   = ((taps_q & ~deg_mask) == '0);
  assign feedback  = ^(lfsr_q & taps_q & deg_mask);
  assign code_bit  = lfsr_q[out_pos[4:0]];
  assign lfsr_step = ((lfsr_q >> 1) & deg_mask) | {feedback, {(WordW-1){1'b0}}};

  // Clip the requested count to the maximum.
  assign count_ext = CmpW'(bit_count_i);
  assign count_sat = (count_ext > CmpW'(MaxBits)) ? RemW'(MaxBits) : RemW'(bit_count_i);

  assign req_accept = in_valid_i && in_ready_o;
  assign rsp_accept = out_valid_o && out_ready_i;

  // Sequencer: check, step one bit per cycle in S_RUN, hold each byte in S_EMIT until taken.
  always_comb begin
    state_d   = state_q;
    lfsr_d    = lfsr_q;
    rem_d     = rem_q;
    bit_idx_d = bit_idx_q;
    byte_d    = byte_q;
    last_d    = last_q;
    status_d  = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          byte_d    = '0;
          bit_idx_d = '0;
          rem_d     = count_sat;
          last_d    = 1'b1;
          state_d   = S_EMIT;
          if (!degree_ok) begin
            status_d = ST_BAD_DEGREE;
          end else if (!g0_ok) begin
            status_d = ST_NO_G0;
          end else if (!taps_ok) begin
            status_d = ST_STRAY_TAPS;
          end else if (bit_count_i == '0) begin
            status_d = ST_ZERO_COUNT;
          end else begin
            status_d = ST_OK;
            last_d   = 1'b0;
            state_d  = S_RUN;
          end
        end
      end
      S_RUN: begin
        lfsr_d              = lfsr_step;
        byte_d[~bit_idx_q]  = code_bit;
        bit_idx_d           = bit_idx_q + 3'd1;
        rem_d               = rem_q - RemW'(1);
        if (rem_q == RemW'(1)) begin
          last_d  = 1'b1;
          state_d = S_EMIT;
        end else if (bit_idx_q == 3'd7) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (rsp_accept) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            byte_d    = '0;
            bit_idx_d = '0;
            state_d   = S_RUN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration registers and the LFSR word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      degree_q <= DegreeReset;
      taps_q   <= TapReset;
      seed_q   <= SeedReset;
      lfsr_q   <= SeedReset;
      last_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      last_q   <= last_d;
      status_q <= status_d;
      lfsr_q   <= lfsr_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_DEGREE: begin
            degree_q <= cfg_wdata_i[DegreeW-1:0];
            lfsr_q   <= seed_q;
          end
          CFG_TAPS: begin
            taps_q <= cfg_wdata_i;
            lfsr_q <= seed_q;
          end
          CFG_SEED: begin
            seed_q <= cfg_wdata_i;
            lfsr_q <= cfg_wdata_i;
          end
          default: begin
            // Writes beyond the register list are ignored.
          end
        endcase
      end
    end
  end

  // Byte assembly and count registers.
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    bit_idx_q <= bit_idx_d;
    byte_q    <= byte_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign code_byte_o = byte_q;
  assign last_byte_o = last_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/core/lscp_checker.sv =====
// ----------------------------------------------------------------------------
// LFSR spreading code packer checker
// Port-level assertions, bound to the packer unit.
// ----------------------------------------------------------------------------
`include "lfsr_spreading_code_packer_unit_assert.svh"

module lscp_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic [7:0] code_byte_o,
  input  logic       last_byte_o,
  input  logic [2:0] status_o
);
  import lscp_pkg::*;

  // A pending result stays offered until it is taken.
  `LSCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // The unit never takes a request while a result is on offer.
  `LSCP_ASSERT_SAME(a_busy_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)

  // An accepted request makes the unit busy in the next cycle.
  `LSCP_ASSERT_NEXT(a_req_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // Every error result is a single, empty, final byte.
  `LSCP_ASSERT_SAME(a_err_last, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), last_byte_o && (code_byte_o == 8'h00))

endmodule

bind lfsr_spreading_code_packer_unit lscp_checker u_lscp_checker (.*);
